FILE: rtl/interval_timer_counter_with_prescaler_defines.svh
// Assertion macros used by the interval timer core.
`ifndef INTERVAL_TIMER_COUNTER_WITH_PRESCALER_DEFINES_SVH
`define INTERVAL_TIMER_COUNTER_WITH_PRESCALER_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define ITC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another one in the following cycle.
`define ITC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/itc_pkg.sv
// Types and constants of the interval timer/counter.
`timescale 1ns / 1ps
package itc_pkg;

  // Counter width and prescale counter width
  localparam int CNT_W = 16;
  localparam int PRE_W = 17;
  localparam int RD_W  = 16;

  // Word operations
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register byte offsets
  localparam logic [6:0] OFS_CLOCK_CTRL   = 7'h00;
  localparam logic [6:0] OFS_COUNTER_CTRL = 7'h0C;
  localparam logic [6:0] OFS_COUNT        = 7'h18;
  localparam logic [6:0] OFS_INTERVAL     = 7'h24;
  localparam logic [6:0] OFS_STATUS       = 7'h54;
  localparam logic [6:0] OFS_ENABLE       = 7'h60;

  // Counter control bit positions
  localparam int BIT_STOP  = 0;
  localparam int BIT_MODE  = 1;
  localparam int BIT_CLEAR = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  reg_offset;
    logic [31:0] write_data;
  } itc_in_t;

  typedef struct packed {
    logic [RD_W-1:0] read_data;
    logic            irq;
  } itc_out_t;

endpackage

FILE: rtl/itc_inreg.sv
// Input register stage of the interval timer.
`timescale 1ns / 1ps
module itc_inreg
  import itc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  itc_in_t item,
  output logic    stage_valid,
  output itc_in_t stage_item,
  input  logic    advance
);

  // Take a new word when empty or when the held word moves on
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

endmodule

FILE: rtl/itc_core.sv
// Timer state registers and per-word update logic.
`timescale 1ns / 1ps
`include "interval_timer_counter_with_prescaler_defines.svh"
module itc_core
  import itc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  itc_in_t  stage_item,
  output itc_out_t res
);

  logic             prescale_on, prescale_on_next;
  logic [3:0]       prescale_exponent, prescale_exponent_next;
  logic [PRE_W-1:0] prescale_count, prescale_count_next;
  logic             counter_stopped, counter_stopped_next;
  logic             interval_mode, interval_mode_next;
  logic [CNT_W-1:0] count_value, count_value_next;
  logic [CNT_W-1:0] interval_limit, interval_limit_next;
  logic             interval_flag, interval_flag_next;
  logic             interval_irq_enable, interval_irq_enable_next;

  logic [PRE_W-1:0] pc_inc;
  logic [PRE_W-1:0] period;
  logic [RD_W-1:0]  rd;
  logic             adv;
  logic [31:0]      d;

  assign d      = stage_item.write_data;
  assign pc_inc = prescale_count + PRE_W'(1);
  assign period = PRE_W'(1) << ({1'b0, prescale_exponent} + 5'd1);

  // Compute next state and read data for the word at the stage
  always_comb begin
    prescale_on_next         = prescale_on;
    prescale_exponent_next   = prescale_exponent;
    prescale_count_next      = prescale_count;
    counter_stopped_next     = counter_stopped;
    interval_mode_next       = interval_mode;
    count_value_next         = count_value;
    interval_limit_next      = interval_limit;
    interval_flag_next       = interval_flag;
    interval_irq_enable_next = interval_irq_enable;
    rd                       = '0;
    adv                      = 1'b0;
    if (fire) begin
      unique case (stage_item.operation)
        OP_TICK: begin
          if (!counter_stopped) begin
            if (prescale_on) begin
              if (pc_inc >= period) begin
                prescale_count_next = '0;
                adv                 = 1'b1;
              end else begin
                prescale_count_next = pc_inc;
              end
            end else begin
              adv = 1'b1;
            end
          end
        end
        OP_READ: begin
          unique case (stage_item.reg_offset)
            OFS_CLOCK_CTRL:   rd = RD_W'({prescale_exponent, prescale_on});
            OFS_COUNTER_CTRL: rd = RD_W'({interval_mode, counter_stopped});
            OFS_COUNT:        rd = RD_W'(count_value);
            OFS_INTERVAL:     rd = RD_W'(interval_limit);
            OFS_STATUS: begin
              rd                 = RD_W'(interval_flag);
              interval_flag_next = 1'b0;
            end
            OFS_ENABLE:       rd = RD_W'(interval_irq_enable);
            default:          rd = '0;
          endcase
        end
        OP_WRITE: begin
          unique case (stage_item.reg_offset)
            OFS_CLOCK_CTRL: begin
              prescale_on_next       = d[0];
              prescale_exponent_next = d[4:1];
            end
            OFS_COUNTER_CTRL: begin
              counter_stopped_next = d[BIT_STOP];
              interval_mode_next   = d[BIT_MODE];
              if (d[BIT_CLEAR]) begin
                count_value_next    = '0;
                prescale_count_next = '0;
              end
            end
            OFS_INTERVAL:   interval_limit_next = d[CNT_W-1:0];
            OFS_ENABLE:     interval_irq_enable_next = d[0];
            default:        ;
          endcase
        end
        default: ;
      endcase
      // Advance the counter, wrapping at the interval in interval mode
      if (adv) begin
        if (interval_mode && (count_value == interval_limit)) begin
          count_value_next   = '0;
          interval_flag_next = 1'b1;
        end else begin
          count_value_next = count_value + CNT_W'(1);
        end
      end
    end
  end

  assign res.read_data = rd;
  assign res.irq       = interval_flag_next & interval_irq_enable_next;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_on         <= 1'b0;
      prescale_exponent   <= '0;
      prescale_count      <= '0;
      counter_stopped     <= 1'b1;
      interval_mode       <= 1'b0;
      count_value         <= '0;
      interval_limit      <= '0;
      interval_flag       <= 1'b0;
      interval_irq_enable <= 1'b0;
    end else begin
      prescale_on         <= prescale_on_next;
      prescale_exponent   <= prescale_exponent_next;
      prescale_count      <= prescale_count_next;
      counter_stopped     <= counter_stopped_next;
      interval_mode       <= interval_mode_next;
      count_value         <= count_value_next;
      interval_limit      <= interval_limit_next;
      interval_flag       <= interval_flag_next;
      interval_irq_enable <= interval_irq_enable_next;
    end
  end

  `ITC_ASSERT_NEXT(a_stopped_holds, clk, rst, fire && (stage_item.operation == OP_TICK) && counter_stopped, $stable(count_value) && $stable(prescale_count), "stopped counter moved on a tick")
  `ITC_ASSERT_NEXT(a_status_read_clears, clk, rst, fire && (stage_item.operation == OP_READ) && (stage_item.reg_offset == OFS_STATUS), !interval_flag, "status read left flag set")
  `ITC_ASSERT_NEXT(a_clear_bit, clk, rst, fire && (stage_item.operation == OP_WRITE) && (stage_item.reg_offset == OFS_COUNTER_CTRL) && stage_item.write_data[BIT_CLEAR], (count_value == '0) && (prescale_count == '0), "counter reset bit did not clear")

endmodule

FILE: rtl/itc_outreg.sv
// Result register of the interval timer.
`timescale 1ns / 1ps
module itc_outreg
  import itc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     stage_valid,
  input  itc_out_t res,
  output logic     advance,
  output logic     result_valid,
  input  logic     result_ready,
  output itc_out_t result
);

  // Load when empty or when the held word is being taken
  assign advance = stage_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= stage_valid;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

FILE: rtl/interval_timer_counter_with_prescaler.sv
// Top level of the register-mapped interval timer/counter.
`timescale 1ns / 1ps
// Each word is a prescaler tick, a register read or a register write; each
// gives one result word (read data and the interrupt line after the word).
// The block takes one word per clock unless a held result stalls it. A word
// accepted sits in the input register; the core computes its result
// combinationally, and the result register loads it when empty or when its
// word is taken, which also updates the counter state. That per-word update sets
// the rate; a held result stalls the input only while both registers are full.
module interval_timer_counter_with_prescaler
  import itc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  itc_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output itc_out_t result
);

  logic     stage_valid;
  itc_in_t  stage_item;
  logic     advance;
  itc_out_t res;

  itc_inreg u_inreg (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .advance     (advance)
  );

  itc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .stage_item (stage_item),
    .res        (res)
  );

  itc_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
